// File: hw/rtl/cam2d_pkg.sv
// ----------------------------------------------------------------------------
// cam2d_pkg
// Types and constants shared by the 2D camera coordinate transform.
// ----------------------------------------------------------------------------
package cam2d_pkg;

   localparam logic OP_W2S = 1'b0;
   localparam logic OP_S2W = 1'b1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CAM_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_W   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_H   = 3'd5;

   localparam logic [11:0] ZOOM_RESET = 12'd256;
   localparam logic [14:0] VP_W_RESET = 15'd640;
   localparam logic [14:0] VP_H_RESET = 15'd480;

   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;

   localparam int DIV_W      = 60;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = DIV_W / DIV_STEP;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] coord_a;
      logic signed [31:0] coord_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_x;
      logic signed [31:0] result_y;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic [11:0]        zoom;
      logic [15:0]        angle;
      logic [13:0]        half_w;
      logic [13:0]        half_h;
   } cfg_type;

   typedef struct packed {
      logic             opcode;
      logic             neg_x;
      logic             neg_y;
      logic [DIV_W-1:0] num_x;
      logic [DIV_W-1:0] num_y;
      rsp_type          scr;
   } div_item_type;

endpackage

// File: hw/rtl/camera_2d_coordinate_transform.sv
// ----------------------------------------------------------------------------
// camera_2d_coordinate_transform
// 2D camera view transform: world to screen and screen to world, fixed point.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the skid stage is empty; depth set by
//   the 15-stage divider, four quotient bits per stage, plus six front stages
//   and the output register.
// Reset: synchronous; clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module camera_2d_coordinate_transform #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SCREEN_BITS      = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cam2d_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cam2d_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write_en,
   input  logic [cam2d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cam2d_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cam2d_pkg::cfg_type cfg;
   logic signed [31:0] cam_x_ff, cam_y_ff;
   logic [11:0]        zoom_ff;
   logic [15:0]        angle_ff;
   logic [14:0]        vp_w_ff, vp_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         zoom_ff  <= cam2d_pkg::ZOOM_RESET;
         angle_ff <= '0;
         vp_w_ff  <= cam2d_pkg::VP_W_RESET;
         vp_h_ff  <= cam2d_pkg::VP_H_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            cam2d_pkg::CSR_CAM_X: cam_x_ff <= csr_wdata;
            cam2d_pkg::CSR_CAM_Y: cam_y_ff <= csr_wdata;
            cam2d_pkg::CSR_ZOOM:  zoom_ff  <= csr_wdata[11:0];
            cam2d_pkg::CSR_ANGLE: angle_ff <= csr_wdata[15:0];
            cam2d_pkg::CSR_VP_W:  vp_w_ff  <= csr_wdata[14:0];
            cam2d_pkg::CSR_VP_H:  vp_h_ff  <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.cam_x  = cam_x_ff;
   assign cfg.cam_y  = cam_y_ff;
   assign cfg.zoom   = zoom_ff;
   assign cfg.angle  = angle_ff;
   assign cfg.half_w = vp_w_ff[14:1];
   assign cfg.half_h = vp_h_ff[14:1];

   logic en;
   logic skid_valid_ff;
   logic out_valid_ff;
   cam2d_pkg::rsp_type out_ff;
   cam2d_pkg::rsp_type skid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: input register
   logic               v1_ff;
   cam2d_pkg::req_type item1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= req_data;
      end
   end

   logic signed [17:0] sin_q16, cos_q16;

   cam2d_sincos #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_sincos (
      .clock   (clock),
      .en      (en),
      .angle   (angle_ff),
      .sin_q16 (sin_q16),
      .cos_q16 (cos_q16)
   );

   logic                    front_valid;
   cam2d_pkg::div_item_type front_item;

   cam2d_front #(
      .SCREEN_BITS(SCREEN_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_item   (item1_ff),
      .cfg       (cfg),
      .sin_q16   (sin_q16),
      .cos_q16   (cos_q16),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   logic [11:0]             divisor;
   logic                    div_valid;
   cam2d_pkg::div_item_type div_item;

   assign divisor = (zoom_ff == 12'd0) ? 12'd1 : zoom_ff;

   cam2d_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .divisor   (divisor),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   function automatic logic signed [61:0] world_sum(input logic neg,
                                                    input logic [cam2d_pkg::DIV_W-1:0] q,
                                                    input logic signed [31:0] cam);
      logic signed [61:0] sq;
      sq = signed'({2'd0, q});
      if (neg) begin
         sq = -sq;
      end
      return sq + 62'(cam);
   endfunction

   cam2d_pkg::rsp_type fin;

   always_comb begin
      logic signed [61:0] wx;
      logic signed [61:0] wy;
      wx  = world_sum(div_item.neg_x, div_item.num_x, cam_x_ff);
      wy  = world_sum(div_item.neg_y, div_item.num_y, cam_y_ff);
      fin = div_item.scr;
      if (div_item.opcode == cam2d_pkg::OP_S2W) begin
         fin.saturated = 1'b0;
         if (wx > 62'sh7FFF_FFFF) begin
            wx            = 62'sh7FFF_FFFF;
            fin.saturated = 1'b1;
         end else if (wx < -62'sh8000_0000) begin
            wx            = -62'sh8000_0000;
            fin.saturated = 1'b1;
         end
         if (wy > 62'sh7FFF_FFFF) begin
            wy            = 62'sh7FFF_FFFF;
            fin.saturated = 1'b1;
         end else if (wy < -62'sh8000_0000) begin
            wy            = -62'sh8000_0000;
            fin.saturated = 1'b1;
         end
         fin.result_x = wx[31:0];
         fin.result_y = wy[31:0];
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (div_valid) begin
         if (out_valid_ff && rsp_stall) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_ff <= skid_ff;
         end
      end else if (div_valid) begin
         if (out_valid_ff && rsp_stall) begin
            skid_ff <= fin;
         end else begin
            out_ff <= fin;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: hw/rtl/cam2d_sincos.sv
// ----------------------------------------------------------------------------
// cam2d_sincos
// Quarter-wave sine table lookup; sine and cosine of the camera angle, Q16.
// ----------------------------------------------------------------------------
module cam2d_sincos #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [17:0] sin_q16,
   output logic signed [17:0] cos_q16
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

   function automatic logic [16:0] sine_entry(input int unsigned i);
      logic [63:0]        x;
      logic [63:0]        t;
      logic [63:0]        q;
      logic signed [63:0] sum;
      x   = 64'(i) * 64'(cam2d_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      t   = x;
      sum = signed'(x);
      for (int k = 1; k <= 7; k++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / 64'((2 * k) * (2 * k + 1));
         if ((k & 1) == 1) begin
            sum = sum - signed'(t);
         end else begin
            sum = sum + signed'(t);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (unsigned'(sum) + 64'd8192) >> 14;
      if (q > 64'd65536) begin
         q = 64'd65536;
      end
      return q[16:0];
   endfunction

   function automatic logic [IDX_W-1:0] rom_addr(input logic [15:0] a);
      logic [31:0]      scaled;
      logic [IDX_W-1:0] idx;
      scaled = (32'(a[13:0]) * 32'(SINE_TABLE_DEPTH)) >> 14;
      idx    = scaled[IDX_W-1:0];
      if (a[14]) begin
         return IDX_W'(SINE_TABLE_DEPTH) - idx;
      end
      return idx;
   endfunction

   logic [16:0] rom [0:SINE_TABLE_DEPTH];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
      assign rom[g] = sine_entry(g);
   end

   logic [15:0]        cos_angle;
   logic [16:0]        sin_mag_ff;
   logic [16:0]        cos_mag_ff;
   logic               sin_neg_ff;
   logic               cos_neg_ff;
   logic signed [17:0] sin_ff;
   logic signed [17:0] cos_ff;

   assign cos_angle = angle + cam2d_pkg::QUARTER_TURN;

   always_ff @(posedge clock) begin
      if (en) begin
         sin_mag_ff <= rom[rom_addr(angle)];
         cos_mag_ff <= rom[rom_addr(cos_angle)];
         sin_neg_ff <= angle[15];
         cos_neg_ff <= cos_angle[15];
         sin_ff     <= sin_neg_ff ? -signed'({1'b0, sin_mag_ff}) : signed'({1'b0, sin_mag_ff});
         cos_ff     <= cos_neg_ff ? -signed'({1'b0, cos_mag_ff}) : signed'({1'b0, cos_mag_ff});
      end
   end

   assign sin_q16 = sin_ff;
   assign cos_q16 = cos_ff;

endmodule

// File: hw/rtl/cam2d_front.sv
// ----------------------------------------------------------------------------
// cam2d_front
// Translate, scale and rotate stages; finishes world to screen and prepares
// the dividend for screen to world.
// ----------------------------------------------------------------------------
module cam2d_front #(
   parameter int SCREEN_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  cam2d_pkg::req_type      in_item,
   input  cam2d_pkg::cfg_type      cfg,
   input  logic signed [17:0]      sin_q16,
   input  logic signed [17:0]      cos_q16,
   output logic                    out_valid,
   output cam2d_pkg::div_item_type out_item
);

   localparam logic signed [32:0] SCR_MAX = 33'((64'd1 << (SCREEN_BITS - 1)) - 64'd1);
   localparam logic signed [32:0] SCR_MIN = -SCR_MAX - 33'sd1;

   // stage 2: translate
   logic               v2_ff;
   logic               op2_ff;
   logic signed [32:0] dx2_ff, dy2_ff;
   logic signed [32:0] dx2_in, dy2_in;

   // stage 3: scale
   logic               v3_ff;
   logic               op3_ff;
   logic signed [45:0] mx3_ff, my3_ff;
   logic signed [45:0] mx3_in, my3_in;
   logic signed [17:0] s3_ff, c3_ff;

   // stage 4: rotate products
   logic               v4_ff;
   logic               op4_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;

   // stage 5: sums
   logic               v5_ff;
   logic               op5_ff;
   logic signed [63:0] sx5_ff, sy5_ff;
   logic signed [63:0] sx5_in, sy5_in;

   // stage 6: finish
   logic                    v6_ff;
   cam2d_pkg::div_item_type item6_ff;
   cam2d_pkg::div_item_type item6_in;

   always_comb begin
      if (in_item.opcode == cam2d_pkg::OP_W2S) begin
         dx2_in = {in_item.coord_a[31], in_item.coord_a} - {cfg.cam_x[31], cfg.cam_x};
         dy2_in = {in_item.coord_b[31], in_item.coord_b} - {cfg.cam_y[31], cfg.cam_y};
      end else begin
         dx2_in = {in_item.coord_a[31], in_item.coord_a} - signed'({19'd0, cfg.half_w});
         dy2_in = {in_item.coord_b[31], in_item.coord_b} - signed'({19'd0, cfg.half_h});
      end
   end

   always_comb begin
      if (op2_ff == cam2d_pkg::OP_W2S) begin
         mx3_in = dx2_ff * signed'({1'b0, cfg.zoom});
         my3_in = dy2_ff * signed'({1'b0, cfg.zoom});
      end else begin
         mx3_in = 46'(dx2_ff);
         my3_in = 46'(dy2_ff);
      end
   end

   always_comb begin
      if (op4_ff == cam2d_pkg::OP_W2S) begin
         sx5_in = p0_ff - p1_ff + signed'({10'd0, cfg.half_w, 40'd0});
         sy5_in = p2_ff + p3_ff + signed'({10'd0, cfg.half_h, 40'd0});
      end else begin
         sx5_in = p0_ff + p1_ff;
         sy5_in = p3_ff - p2_ff;
      end
   end

   function automatic logic signed [32:0] trunc_pixel(input logic signed [63:0] v);
      logic signed [24:0] q;
      q = signed'({v[63], v[63:40]}) + signed'({24'd0, v[63] & (|v[39:0])});
      return 33'(q);
   endfunction

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v[63] ? unsigned'(-v) : unsigned'(v);
   endfunction

   always_comb begin
      logic signed [32:0] qx;
      logic signed [32:0] qy;
      logic [63:0]        mag_x;
      logic [63:0]        mag_y;
      qx    = trunc_pixel(sx5_ff);
      qy    = trunc_pixel(sy5_ff);
      mag_x = magnitude(sx5_ff);
      mag_y = magnitude(sy5_ff);
      item6_in                = '0;
      item6_in.opcode         = op5_ff;
      if (op5_ff == cam2d_pkg::OP_W2S) begin
         if (qx > SCR_MAX) begin
            qx = SCR_MAX;
            item6_in.scr.saturated = 1'b1;
         end else if (qx < SCR_MIN) begin
            qx = SCR_MIN;
            item6_in.scr.saturated = 1'b1;
         end
         if (qy > SCR_MAX) begin
            qy = SCR_MAX;
            item6_in.scr.saturated = 1'b1;
         end else if (qy < SCR_MIN) begin
            qy = SCR_MIN;
            item6_in.scr.saturated = 1'b1;
         end
         item6_in.scr.result_x = qx[31:0];
         item6_in.scr.result_y = qy[31:0];
      end else begin
         item6_in.neg_x = sx5_ff[63];
         item6_in.neg_y = sy5_ff[63];
         item6_in.num_x = {mag_x[cam2d_pkg::DIV_W-9:0], 8'd0};
         item6_in.num_y = {mag_y[cam2d_pkg::DIV_W-9:0], 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff   <= in_item.opcode;
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         op3_ff   <= op2_ff;
         mx3_ff   <= mx3_in;
         my3_ff   <= my3_in;
         s3_ff    <= sin_q16;
         c3_ff    <= cos_q16;
         op4_ff   <= op3_ff;
         p0_ff    <= mx3_ff * c3_ff;
         p1_ff    <= my3_ff * s3_ff;
         p2_ff    <= mx3_ff * s3_ff;
         p3_ff    <= my3_ff * c3_ff;
         op5_ff   <= op4_ff;
         sx5_ff   <= sx5_in;
         sy5_ff   <= sy5_in;
         item6_ff <= item6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_item  = item6_ff;

endmodule

// File: hw/rtl/cam2d_div.sv
// ----------------------------------------------------------------------------
// cam2d_div
// Pipelined restoring divider, four quotient bits per stage, both axes.
// ----------------------------------------------------------------------------
module cam2d_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic [11:0]             divisor,
   input  logic                    in_valid,
   input  cam2d_pkg::div_item_type in_item,
   output logic                    out_valid,
   output cam2d_pkg::div_item_type out_item
);

   localparam int N = cam2d_pkg::DIV_STAGES;

   typedef struct packed {
      logic [cam2d_pkg::DIV_W-1:0] num;
      logic [11:0]                 rem;
   } div_lane_type;

   function automatic div_lane_type div_steps(input div_lane_type cur, input logic [11:0] d);
      logic [12:0]  t;
      div_lane_type nxt;
      nxt = cur;
      for (int j = 0; j < cam2d_pkg::DIV_STEP; j++) begin
         t       = {nxt.rem, nxt.num[cam2d_pkg::DIV_W-1]};
         nxt.num = {nxt.num[cam2d_pkg::DIV_W-2:0], 1'b0};
         if (t >= {1'b0, d}) begin
            t          = t - {1'b0, d};
            nxt.num[0] = 1'b1;
         end
         nxt.rem = t[11:0];
      end
      return nxt;
   endfunction

   logic                    valid_ff [0:N-1];
   cam2d_pkg::div_item_type item_ff  [0:N-1];
   logic [11:0]             rem_x_ff [0:N-1];
   logic [11:0]             rem_y_ff [0:N-1];
   cam2d_pkg::div_item_type item_in  [0:N-1];
   logic [11:0]             rem_x_in [0:N-1];
   logic [11:0]             rem_y_in [0:N-1];

   always_comb begin
      div_lane_type lx;
      div_lane_type ly;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            item_in[k] = in_item;
            lx         = div_steps({in_item.num_x, 12'd0}, divisor);
            ly         = div_steps({in_item.num_y, 12'd0}, divisor);
         end else begin
            item_in[k] = item_ff[k-1];
            lx         = div_steps({item_ff[k-1].num_x, rem_x_ff[k-1]}, divisor);
            ly         = div_steps({item_ff[k-1].num_y, rem_y_ff[k-1]}, divisor);
         end
         item_in[k].num_x = lx.num;
         item_in[k].num_y = ly.num;
         rem_x_in[k]      = lx.rem;
         rem_y_in[k]      = ly.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < N; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            item_ff[k]  <= item_in[k];
            rem_x_ff[k] <= rem_x_in[k];
            rem_y_ff[k] <= rem_y_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_item  = item_ff[N-1];

endmodule

// File: tb/sv/tb_camera_2d_coordinate_transform.sv
// ----------------------------------------------------------------------------
// tb_camera_2d_coordinate_transform
// Self-checking bench for the 2D camera coordinate transform. A short table of
// directed points is followed by random points. Each result is checked against
// its table value or a bit-exact fixed-point model of both transforms in the bench.
// Camera settings are changed between phases and include the extremes. Both
// channels idle at random rates, and one long output hold fills the pipeline.
// ----------------------------------------------------------------------------
module tb_camera_2d_coordinate_transform;

   localparam int TAB_DEPTH   = 1024;
   localparam int SCR_BITS    = 16;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 225;
   localparam int DRAIN_WAIT  = 40;
   localparam logic [cam2d_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [cam2d_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic               op;
      logic [31:0]        a;
      logic [31:0]        b;
      bit                 typed;
      cam2d_pkg::rsp_type want;
   } point_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   cam2d_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   cam2d_pkg::rsp_type rsp_data;
   logic               csr_write_en;
   logic [cam2d_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cam2d_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic signed [31:0] view_cam_x, view_cam_y;
   logic [11:0] view_zoom;
   logic [15:0] view_angle;
   logic [14:0] view_w, view_h;
   longint unsigned quarter_sine[TAB_DEPTH+1];

   cam2d_pkg::rsp_type pending_points[$];
   point_row_type directed[$];
   int mismatches, checked, sent, clamped_seen;
   int send_idle_pct, rsp_idle_pct;
   bit hold_request;

   camera_2d_coordinate_transform u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void build_sine();
      longint unsigned x, t, q;
      longint sum;
      for (int i = 0; i <= TAB_DEPTH; i++) begin
         x = longint'(i) * longint'(cam2d_pkg::HALF_PI_Q30) / TAB_DEPTH;
         t = x;
         sum = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
         end
         if (sum < 0) sum = 0;
         q = (longint'(sum) + 8192) >> 14;
         if (q > 65536) q = 65536;
         quarter_sine[i] = q;
      end
   endfunction

   function automatic longint sine_of(logic [15:0] ang);
      int idx;
      longint v;
      idx = (int'(ang[13:0]) * TAB_DEPTH) >> 14;
      v = ang[14] ? longint'(quarter_sine[TAB_DEPTH - idx]) : longint'(quarter_sine[idx]);
      return ang[15] ? -v : v;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi, ref bit sat);
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic cam2d_pkg::rsp_type transform_point(logic op, logic [31:0] a,
                                                          logic [31:0] b);
      longint s, c, rx, ry, zx, zy, px, py, z, hw, hh, lim;
      bit sat;
      cam2d_pkg::rsp_type r;
      sat = 1'b0;
      s = sine_of(view_angle);
      c = sine_of(view_angle + cam2d_pkg::QUARTER_TURN);
      hw = longint'(view_w >> 1);
      hh = longint'(view_h >> 1);
      if (op == cam2d_pkg::OP_W2S) begin
         lim = (longint'(1) << (SCR_BITS - 1)) - 1;
         zx = (longint'(signed'(a)) - longint'(view_cam_x)) * longint'(view_zoom);
         zy = (longint'(signed'(b)) - longint'(view_cam_y)) * longint'(view_zoom);
         rx = (zx * c - zy * s + hw * (longint'(1) << 40)) / (longint'(1) << 40);
         ry = (zx * s + zy * c + hh * (longint'(1) << 40)) / (longint'(1) << 40);
         rx = clamp(rx, -lim - 1, lim, sat);
         ry = clamp(ry, -lim - 1, lim, sat);
      end else begin
         z = (view_zoom != 0) ? longint'(view_zoom) : 1;
         px = longint'(signed'(a)) - hw;
         py = longint'(signed'(b)) - hh;
         rx = (px * c + py * s) * 256 / z + longint'(view_cam_x);
         ry = (py * c - px * s) * 256 / z + longint'(view_cam_y);
         rx = clamp(rx, -64'sd2147483648, 64'sd2147483647, sat);
         ry = clamp(ry, -64'sd2147483648, 64'sd2147483647, sat);
      end
      r.result_x  = rx[31:0];
      r.result_y  = ry[31:0];
      r.saturated = sat;
      return r;
   endfunction

   task automatic csr_write(logic [cam2d_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = val;
      case (idx)
         cam2d_pkg::CSR_CAM_X: view_cam_x = val;
         cam2d_pkg::CSR_CAM_Y: view_cam_y = val;
         cam2d_pkg::CSR_ZOOM:  view_zoom  = val[11:0];
         cam2d_pkg::CSR_ANGLE: view_angle = val[15:0];
         cam2d_pkg::CSR_VP_W:  view_w     = val[14:0];
         cam2d_pkg::CSR_VP_H:  view_h     = val[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_phase(int p);
      logic [31:0] cx, cy, zm, an, vw, vh;
      cx = $urandom;
      cy = $urandom;
      zm = $urandom_range(26, 2560);
      an = $urandom;
      vw = $urandom_range(0, 2047);
      vh = $urandom_range(0, 2047);
      case (p)
         1: begin
            cx = 32'h8000_0000; cy = 32'h7FFF_FFFF; zm = 0;
            an = 32'(cam2d_pkg::QUARTER_TURN);
            vw = 0; vh = 0;
         end
         2: begin
            cx = 32'h7FFF_FFFF; cy = 32'h8000_0000; zm = 32'hFFFF_FFFF;
            an = 32'hFFFF_FFFF; vw = 32'h7FFF; vh = 32'hFFFF_FFFF;
         end
         3: zm = 26;
         4: begin
            zm = 2560; an = 32'h8000;
         end
         default: zm = 1;
      endcase
      csr_write(cam2d_pkg::CSR_CAM_X, cx);
      csr_write(cam2d_pkg::CSR_CAM_Y, cy);
      csr_write(cam2d_pkg::CSR_ZOOM, zm);
      csr_write(cam2d_pkg::CSR_ANGLE, an);
      csr_write(cam2d_pkg::CSR_VP_W, vw);
      csr_write(cam2d_pkg::CSR_VP_H, vh);
      csr_write(CSR_SPARE_A, $urandom);
      csr_write(CSR_SPARE_B, $urandom);
   endtask

   task automatic transfer_point(logic op, logic [31:0] a, logic [31:0] b, bit typed,
                                 cam2d_pkg::rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.opcode  = op;
      req_data.coord_a = a;
      req_data.coord_b = b;
      do @(posedge clock); while (req_stall);
      pending_points.push_back(typed ? want : transform_point(op, a, b));
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coord(logic op, logic signed [31:0] cam, int span);
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: begin
            if (op == cam2d_pkg::OP_W2S)
               return cam + (int'($urandom_range(0, 1 << 25)) - (1 << 24));
            return int'($urandom_range(0, span + 64)) - 32;
         end
      endcase
   endfunction

   task automatic wait_idle();
      int guard;
      guard = 0;
      while (pending_points.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic point_row_type mk_row(logic op, logic [31:0] a, logic [31:0] b,
                                            bit typed, logic [31:0] x, logic [31:0] y,
                                            logic sat);
      point_row_type r;
      r.op = op; r.a = a; r.b = b; r.typed = typed;
      r.want.result_x = x; r.want.result_y = y; r.want.saturated = sat;
      return r;
   endfunction

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 300;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cam2d_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: x=%0d y=%0d sat=%0b", $signed(rsp_data.result_x),
                        $signed(rsp_data.result_y), rsp_data.saturated);
         end else begin
            want = pending_points.pop_front();
            checked++;
            if (want.saturated) clamped_seen++;
            if (rsp_data.result_x !== want.result_x || rsp_data.result_y !== want.result_y ||
                rsp_data.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                           $signed(want.result_x), $signed(want.result_y), want.saturated,
                           $signed(rsp_data.result_x), $signed(rsp_data.result_y),
                           rsp_data.saturated);
            end
         end
      end
   end

   initial begin
      logic op;
      cam2d_pkg::rsp_type none;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_request = 1'b0;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      none = '0;
      mismatches = 0; checked = 0; sent = 0; clamped_seen = 0;
      view_cam_x = 0; view_cam_y = 0; view_zoom = cam2d_pkg::ZOOM_RESET; view_angle = 0;
      view_w = cam2d_pkg::VP_W_RESET; view_h = cam2d_pkg::VP_H_RESET;
      build_sine();

      directed.push_back(mk_row(cam2d_pkg::OP_W2S, 0, 0, 1, 320, 240, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_S2W, 320, 240, 1, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_W2S, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                                32'd32767, 32'hFFFF_80F0, 1));
      directed.push_back(mk_row(cam2d_pkg::OP_S2W, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                32'h8000_0000, 32'h7FFF_FFFF, 1));
      directed.push_back(mk_row(cam2d_pkg::OP_W2S, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_W2S, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_S2W, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_S2W, 639, 479, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_S2W, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_W2S, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_W2S, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
      directed.push_back(mk_row(cam2d_pkg::OP_S2W, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         transfer_point(directed[i].op, directed[i].a, directed[i].b, directed[i].typed,
                        directed[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            req_valid = 1'b0;
            wait_idle();
            load_phase(p);
         end
         case (p / 2)
            0: begin
               send_idle_pct = 7; rsp_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85; rsp_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0; rsp_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 20) hold_request = 1'b1;
            op = 1'($urandom_range(0, 1));
            transfer_point(op, pick_coord(op, view_cam_x, int'(view_w)),
                           pick_coord(op, view_cam_y, int'(view_h)), 0, none);
         end
      end
      req_valid = 1'b0;
      wait_idle();

      $display("covered %0d points in %0d camera settings, %0d results checked, %0d clamped",
               sent, NUM_PHASES, checked, clamped_seen);
      if (mismatches == 0 && pending_points.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
